// ----- src/assert_macros.svh -----
// Assertion macros shared by the netpbm stream decoder RTL.
// No dependencies; included by the files that hold concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define NBSD_ASSERT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define NBSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/nbsd_pkg.sv -----
// Shared types and constants for the netpbm binary stream decoder.
// No dependencies; used by nbsd_parser and the top level.
`timescale 1ns / 1ps

package nbsd_pkg;

   localparam int DIM_W   = 13;
   localparam int BYTE_W  = 8;

   // Saturation value of the decimal accumulator
   localparam logic [DIM_W-1:0] ACC_SAT = 13'd8191;

   localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
   localparam logic [BYTE_W-1:0] CH_FIVE  = 8'h35;
   localparam logic [BYTE_W-1:0] CH_SIX   = 8'h36;
   localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [DIM_W-1:0]  MAXVAL_OK = 13'd255;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_MAGIC  = 3'd1,
      ST_BAD_NUMBER = 3'd2,
      ST_BAD_MAXVAL = 3'd3,
      ST_ZERO_DIM   = 3'd4,
      ST_TOO_LARGE  = 3'd5,
      ST_TRUNCATED  = 3'd6
   } status_type;

   typedef struct packed {
      status_type        status;
      logic              finished;
      logic [1:0]        channel_count;
      logic [DIM_W-1:0]  image_height;
      logic [DIM_W-1:0]  image_width;
      logic              pixel_valid;
      logic [BYTE_W-1:0] pixel_value;
   } result_type;

endpackage

// ----- src/nbsd_parser.sv -----
// Header parser and pixel counter: one byte per enabled step, result is combinational.
// Depends on nbsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nbsd_parser #(
   parameter int MAX_DIM = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             step_byte,
   input  logic                   step_last,
   output logic                   res_valid,
   output nbsd_pkg::result_type   res
);
   import nbsd_pkg::*;

   localparam int DIM_LIMIT = (MAX_DIM < 8190) ? MAX_DIM : 8190;
   localparam int CNT_W     = (DIM_LIMIT > 1) ? $clog2(DIM_LIMIT) : 1;

   typedef enum logic [2:0] {
      PH_P, PH_KIND, PH_SKIP, PH_COMMENT, PH_DIGITS, PH_PIXELS, PH_DONE
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [1:0]       idx_ff, idx_in;
   logic [DIM_W-1:0] acc_ff, acc_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [1:0]       chan_ff, chan_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [1:0]       sample_ff, sample_in;

   logic             sk_space, sk_hash, sk_digit, skip_bad;
   phase_type        skip_phase;
   logic [3:0]       digit;
   logic [16:0]      acc_next;
   logic [DIM_W-1:0] acc_sat;
   logic             fin, pvalid;
   status_type       st, hc;

   function automatic status_type header_check(input logic [DIM_W-1:0] maxv,
                                               input logic [DIM_W-1:0] w,
                                               input logic [DIM_W-1:0] h);
      status_type r;
      if (maxv != MAXVAL_OK)
         r = ST_BAD_MAXVAL;
      else if (w == '0 || h == '0)
         r = ST_ZERO_DIM;
      else if (w > DIM_W'(DIM_LIMIT) || h > DIM_W'(DIM_LIMIT))
         r = ST_TOO_LARGE;
      else
         r = ST_OK;
      return r;
   endfunction

   // byte classes for the header
   assign sk_space = (step_byte == CH_SPACE) || (step_byte >= CH_TAB && step_byte <= CH_CR);
   assign sk_hash  = (step_byte == CH_HASH);
   assign sk_digit = (step_byte >= CH_ZERO) && (step_byte <= CH_NINE);
   assign digit    = step_byte[3:0];
   assign skip_bad = !sk_space && !sk_hash && !sk_digit;
   assign skip_phase = sk_hash ? PH_COMMENT : (sk_digit ? PH_DIGITS : PH_SKIP);

   // acc * 10 + digit, saturating
   assign acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {13'd0, digit};
   assign acc_sat  = (acc_next > {4'd0, ACC_SAT}) ? ACC_SAT : acc_next[DIM_W-1:0];

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      width_in  = width_ff;
      height_in = height_ff;
      chan_in   = chan_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      sample_in = sample_ff;
      fin       = 1'b0;
      pvalid    = 1'b0;
      st        = ST_OK;
      hc        = ST_OK;
      res       = '0;

      unique case (phase_ff)
         PH_P: begin
            if (step_byte != CH_P) begin
               st  = ST_BAD_MAGIC;
               fin = 1'b1;
            end else begin
               phase_in = PH_KIND;
            end
         end
         PH_KIND: begin
            if (step_byte == CH_FIVE) begin
               chan_in  = 2'd1;
               phase_in = PH_SKIP;
            end else if (step_byte == CH_SIX) begin
               chan_in  = 2'd3;
               phase_in = PH_SKIP;
            end else begin
               st  = ST_BAD_MAGIC;
               fin = 1'b1;
            end
         end
         PH_SKIP: begin
            phase_in = skip_phase;
            if (sk_digit) acc_in = DIM_W'(digit);
            if (skip_bad) begin
               st  = ST_BAD_NUMBER;
               fin = 1'b1;
            end
         end
         PH_COMMENT: begin
            if (step_byte == CH_LF) phase_in = PH_SKIP;
         end
         PH_DIGITS: begin
            if (sk_digit) begin
               acc_in = acc_sat;
            end else if (idx_ff == 2'd0 || idx_ff == 2'd1) begin
               if (idx_ff == 2'd0) width_in = acc_ff;
               else                height_in = acc_ff;
               idx_in   = idx_ff + 2'd1;
               phase_in = skip_phase;
               if (sk_digit) acc_in = DIM_W'(digit);
               if (skip_bad) begin
                  st  = ST_BAD_NUMBER;
                  fin = 1'b1;
               end
            end else begin
               // maxval ends here; this byte is the dropped separator
               hc = header_check(acc_ff, width_ff, height_ff);
               if (hc != ST_OK) begin
                  st  = hc;
                  fin = 1'b1;
               end else begin
                  phase_in  = PH_PIXELS;
                  col_in    = '0;
                  row_in    = '0;
                  sample_in = '0;
               end
            end
         end
         PH_PIXELS: begin
            pvalid = 1'b1;
            if ({1'b0, sample_ff} + 3'd1 < {1'b0, chan_ff}) begin
               sample_in = sample_ff + 2'd1;
            end else begin
               sample_in = '0;
               if (14'(col_ff) + 14'd1 < {1'b0, width_ff}) begin
                  col_in = col_ff + CNT_W'(1);
               end else begin
                  col_in = '0;
                  if (14'(row_ff) + 14'd1 < {1'b0, height_ff})
                     row_in = row_ff + CNT_W'(1);
                  else
                     fin = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      // end of file before the image is complete
      if (step_last && !fin && phase_in != PH_DONE) begin
         fin = 1'b1;
         if (phase_in == PH_P || phase_in == PH_KIND) begin
            st = ST_BAD_MAGIC;
         end else if (phase_in == PH_DIGITS && idx_in == 2'd2) begin
            hc = header_check(acc_in, width_in, height_in);
            st = (hc == ST_OK) ? ST_TRUNCATED : hc;
         end else begin
            st = ST_TRUNCATED;
         end
      end

      res.pixel_value   = pvalid ? step_byte : 8'd0;
      res.pixel_valid   = pvalid;
      res.image_width   = width_in;
      res.image_height  = height_in;
      res.channel_count = chan_in;
      res.finished      = fin;
      res.status        = st;

      if (fin) phase_in = PH_DONE;

      if (step_last) begin
         phase_in  = PH_P;
         idx_in    = '0;
         acc_in    = '0;
         width_in  = '0;
         height_in = '0;
         chan_in   = '0;
         col_in    = '0;
         row_in    = '0;
         sample_in = '0;
      end
   end

   assign res_valid = fin || pvalid;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_P;
         idx_ff    <= '0;
         acc_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         chan_ff   <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         sample_ff <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         acc_ff    <= acc_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         chan_ff   <= chan_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         sample_ff <= sample_in;
      end
   end

   `NBSD_ASSERT(a_pixel_phase, clock, reset, res_valid && res.pixel_valid, phase_ff == PH_PIXELS, "pixel outside pixel phase")
   `NBSD_ASSERT(a_ok_is_pixel, clock, reset, res_valid && res.finished && res.status == ST_OK, res.pixel_valid, "clean finish without final pixel")
   `NBSD_ASSERT_NEXT(a_eof_idle, clock, reset, step_en && step_last, phase_ff == PH_P && chan_ff == 2'd0, "end of file did not return to idle")

endmodule

// ----- src/netpbm_binary_stream_decoder.sv -----
// Top level of the binary PGM/PPM stream decoder: input register, parser, result register.
// Depends on nbsd_pkg, nbsd_parser and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  Dir  tdata fields (low bit up)                          tuser        tlast
// req      in   data_byte[7:0]                                     -            is_last
// rsp      out  pixel_value[7:0], image_width[20:8],               pixel_valid  finished
//               image_height[33:21], channel_count[35:34],
//               status[38:36], zero pad[39]
//
// One byte per cycle sustained while rsp is not stalled; an accepted byte passes
// the input register, then the parser logic into the result register.
// Bytes that produce no result (header, skipped tail) leave the result register empty.
// Reset is synchronous, active high, and returns the parser to expect 'P'.
// A stalled rsp holds the result register; the input register keeps taking
// a byte until it too is full, so req_tready drops only when both are held.

module netpbm_binary_stream_decoder #(
   parameter int MAX_DIM = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tlast,   // is_last
   // response side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // pixel_value, image_width, image_height,
                                    // channel_count, status, pad
   output logic        rsp_tuser,   // pixel_valid
   output logic        rsp_tlast    // finished
);
   import nbsd_pkg::*;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;

   logic       out_free;
   logic       step_en;
   logic       par_valid;
   result_type par_res;

   // result register free when empty or being drained this cycle
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_en    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   assign s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   assign out_valid_in = out_free ? (step_en && par_valid) : out_valid_ff;

   nbsd_parser #(
      .MAX_DIM (MAX_DIM)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .step_byte (s1_byte_ff),
      .step_last (s1_last_ff),
      .res_valid (par_valid),
      .res       (par_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (out_free) begin
         out_res_ff <= par_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_res_ff.status, out_res_ff.channel_count,
                        out_res_ff.image_height, out_res_ff.image_width,
                        out_res_ff.pixel_value};
   assign rsp_tuser  = out_res_ff.pixel_valid;
   assign rsp_tlast  = out_res_ff.finished;

   `NBSD_ASSERT(a_no_step_on_stall, clock, reset, rsp_tvalid && !rsp_tready, !step_en, "parser stepped while result register held")
   `NBSD_ASSERT(a_tready_low_full, clock, reset, !req_tready, s1_valid_ff && out_valid_ff, "input stalled without both registers full")
   `NBSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp changed while stalled")

endmodule
